/* src/crdm_pkg.sv */
package crdm_pkg;

    localparam int COLS = 32;
    localparam int NUM_STREAMS = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_ACC = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    localparam logic [1:0] STAT_OK = 2'd0;
    localparam logic [1:0] STAT_IGNORED = 2'd1;
    localparam logic [1:0] STAT_BAD_READ = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_D = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_E = 2'd1;

    localparam logic [8:0] LENGTH_D_RESET = 9'd40;
    localparam logic [14:0] LENGTH_E_RESET = 15'd120;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ACC = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_REPLY = 2'd3;

    localparam logic signed [7:0] NULL_MARK = -8'sd128;
    localparam logic signed [7:0] SAT_LIMIT = 8'sd127;

    localparam logic [4:0] COL_PERM [0:COLS-1] = '{
        5'd1, 5'd17, 5'd9, 5'd25, 5'd5, 5'd21, 5'd13, 5'd29,
        5'd3, 5'd19, 5'd11, 5'd27, 5'd7, 5'd23, 5'd15, 5'd31,
        5'd0, 5'd16, 5'd8, 5'd24, 5'd4, 5'd20, 5'd12, 5'd28,
        5'd2, 5'd18, 5'd10, 5'd26, 5'd6, 5'd22, 5'd14, 5'd30
    };

    typedef struct packed {
        logic [1:0]        func;
        logic signed [7:0] sample;
        logic [1:0]        stream;
        logic [7:0]        bit_index;
    } req_t;

    typedef struct packed {
        logic signed [7:0] soft_value;
        logic [1:0]        status;
    } rsp_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic signed [7:0] sample;
        logic [1:0]        status;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

endpackage

/* src/crdm_queue.sv */
module crdm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_next;
    logic [PW:0]      count_next;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == (PW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

/* src/crdm_front.sv */
module crdm_front #(
    parameter int MAX_ROWS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [crdm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [crdm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  crdm_pkg::req_t                      req_data,
    input  logic                                init_busy,
    input  logic                                q_full,
    output logic                                q_push,
    output crdm_pkg::cmd_t                      q_cmd,
    output logic [$clog2(3*32*MAX_ROWS)-1:0]    q_addr
);
    import crdm_pkg::*;

    localparam int SPAN = COLS * MAX_ROWS;
    localparam int AW = $clog2(NUM_STREAMS * SPAN);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [8:0]     length_d_reg;
    logic [14:0]    length_e_reg;
    logic [14:0]    count_reg;
    logic [14:0]    count_next;
    logic [1:0]     cur_stream_reg;
    logic [4:0]     cur_col_reg;
    logic [RIW-1:0] cur_row_reg;
    logic [1:0]     cur_stream_next;
    logic [4:0]     cur_col_next;
    logic [RIW-1:0] cur_row_next;

    logic [8:0]     eff_d;
    logic [9:0]     rows_sum;
    logic [RW-1:0]  rows;
    logic [4:0]     shift;
    logic [1:0]     cs;
    logic [4:0]     cc;
    logic [RIW-1:0] cr;
    logic [1:0]     ts;
    logic [4:0]     tc;
    logic [RIW-1:0] tr;
    logic [1:0]     ns;
    logic [4:0]     nc;
    logic [RIW-1:0] nr;
    logic [RW-1:0]  row_inc;
    logic [31:0]    mask;
    logic           found_same;
    logic [4:0]     pick_same;
    logic [4:0]     pick_first;
    logic [4:0]     pcol;
    logic [AW-1:0]  acc_addr;
    logic [AW-1:0]  rd_addr;
    logic signed [7:0] clip_sample;
    logic           accept;
    logic           cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we = cfg_valid && cfg_ready;
    assign req_ready = !q_full && !init_busy;
    assign accept = req_valid && req_ready;
    assign q_push = accept;

    always_comb
    begin
        eff_d = length_d_reg;
        if (length_d_reg == 9'd0)
        begin
            eff_d = 9'd1;
        end
        else if (32'(length_d_reg) > SPAN)
        begin
            eff_d = 9'(SPAN);
        end
        rows_sum = {1'b0, eff_d} + 10'd31;
        rows = RW'(rows_sum[9:5]);
        shift = 5'(6'd32 - {1'b0, eff_d[4:0]});
    end

    always_comb
    begin
        cs = cur_stream_reg;
        cc = cur_col_reg;
        cr = cur_row_reg;
        if (cs > 2'd2 || RW'(cr) >= rows)
        begin
            cs = '0;
            cc = '0;
            cr = '0;
        end

        for (int j = 0; j < COLS; j++)
        begin
            mask[j] = (COL_PERM[j] >= shift);
        end
        found_same = 1'b0;
        pick_same = '0;
        pick_first = '0;
        for (int j = COLS - 1; j >= 0; j--)
        begin
            if (mask[j] && 5'(j) >= cc)
            begin
                found_same = 1'b1;
                pick_same = 5'(j);
            end
            if (mask[j])
            begin
                pick_first = 5'(j);
            end
        end

        ts = cs;
        tc = cc;
        tr = cr;
        if (cr == '0 && !mask[cc])
        begin
            if (rows > RW'(1))
            begin
                tr = RIW'(1);
            end
            else if (found_same)
            begin
                tc = pick_same;
            end
            else
            begin
                tc = pick_first;
                ts = (cs == 2'd2) ? 2'd0 : cs + 2'd1;
            end
        end

        row_inc = RW'(tr) + RW'(1);
        ns = ts;
        nc = tc;
        nr = RIW'(row_inc);
        if (row_inc >= rows)
        begin
            nr = '0;
            nc = tc + 5'd1;
            if (tc == 5'd31)
            begin
                ns = (ts == 2'd2) ? 2'd0 : ts + 2'd1;
            end
        end

        pcol = COL_PERM[tc];
        acc_addr = AW'(SPAN) * AW'(ts) + AW'({tr, 5'b0}) + AW'(pcol);
        rd_addr = AW'(SPAN) * AW'(req_data.stream) + AW'(req_data.bit_index) + AW'(shift);
        clip_sample = (req_data.sample == NULL_MARK) ? -SAT_LIMIT : req_data.sample;
    end

    always_comb
    begin
        q_cmd.kind = CMD_REPLY;
        q_cmd.sample = clip_sample;
        q_cmd.status = STAT_OK;
        q_addr = rd_addr;
        count_next = count_reg;
        cur_stream_next = cur_stream_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (accept)
        begin
            case (req_data.func)
                FUNC_CLEAR:
                begin
                    q_cmd.kind = CMD_CLEAR;
                    count_next = '0;
                    cur_stream_next = '0;
                    cur_col_next = '0;
                    cur_row_next = '0;
                end
                FUNC_ACC:
                begin
                    if (count_reg >= length_e_reg)
                    begin
                        q_cmd.status = STAT_IGNORED;
                    end
                    else
                    begin
                        q_cmd.kind = CMD_ACC;
                        q_addr = acc_addr;
                        count_next = count_reg + 15'd1;
                        cur_stream_next = ns;
                        cur_col_next = nc;
                        cur_row_next = nr;
                    end
                end
                FUNC_READ:
                begin
                    if (req_data.stream > 2'd2 || {1'b0, req_data.bit_index} >= eff_d)
                    begin
                        q_cmd.status = STAT_BAD_READ;
                    end
                    else
                    begin
                        q_cmd.kind = CMD_READ;
                    end
                end
                default:
                begin
                    q_cmd.kind = CMD_REPLY;
                end
            endcase
        end
        if (cfg_we && cfg_index == CFG_LENGTH_D)
        begin
            cur_stream_next = '0;
            cur_col_next = '0;
            cur_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_d_reg <= LENGTH_D_RESET;
            length_e_reg <= LENGTH_E_RESET;
            count_reg <= '0;
            cur_stream_reg <= '0;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_LENGTH_D)
            begin
                length_d_reg <= cfg_data[8:0];
            end
            if (cfg_we && cfg_index == CFG_LENGTH_E)
            begin
                length_e_reg <= cfg_data;
            end
            count_reg <= count_next;
            cur_stream_reg <= cur_stream_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
        end
    end

endmodule

/* src/crdm_back.sv */
module crdm_back #(
    parameter int MAX_ROWS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  crdm_pkg::cmd_t                      q_cmd,
    input  logic [$clog2(3*32*MAX_ROWS)-1:0]    q_addr,
    output logic                                q_pop,
    output logic                                init_busy,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output crdm_pkg::rsp_t                      rsp_data
);
    import crdm_pkg::*;

    localparam int DEPTH = NUM_STREAMS * COLS * MAX_ROWS;
    localparam int AW = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_ACC = 2'd3;

    logic signed [7:0] mem [DEPTH];

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [AW-1:0]     sweep_reg;
    logic [AW-1:0]     sweep_next;
    logic              reply_reg;
    logic              reply_next;
    logic signed [7:0] sample_reg;
    logic [AW-1:0]     addr_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    rsp_t              out_data_reg;
    rsp_t              out_data_next;
    logic signed [7:0] rdata_reg;

    logic              re;
    logic              we;
    logic [AW-1:0]     waddr;
    logic signed [7:0] wdata;
    logic signed [8:0] sum;
    logic signed [7:0] sat;
    logic              load;
    logic              slot_free;

    assign rsp_valid = out_valid_reg;
    assign rsp_data = out_data_reg;
    assign init_busy = (state_reg == S_SWEEP) && !reply_reg;
    assign slot_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        sum = 9'(rdata_reg) + 9'(sample_reg);
        sat = sum[7:0];
        if (sum > 9'(SAT_LIMIT))
        begin
            sat = SAT_LIMIT;
        end
        else if (sum < -9'(SAT_LIMIT))
        begin
            sat = -SAT_LIMIT;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        reply_next = reply_reg;
        q_pop = 1'b0;
        re = 1'b0;
        we = 1'b0;
        waddr = addr_reg;
        wdata = sat;
        load = 1'b0;
        out_data_next = out_data_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty && slot_free)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        CMD_CLEAR:
                        begin
                            state_next = S_SWEEP;
                            sweep_next = '0;
                            reply_next = 1'b1;
                        end
                        CMD_ACC:
                        begin
                            re = 1'b1;
                            state_next = S_ACC;
                        end
                        CMD_READ:
                        begin
                            re = 1'b1;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            load = 1'b1;
                            out_data_next.soft_value = '0;
                            out_data_next.status = q_cmd.status;
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                we = 1'b1;
                waddr = sweep_reg;
                wdata = '0;
                if (sweep_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                    reply_next = 1'b0;
                    if (reply_reg)
                    begin
                        load = 1'b1;
                        out_data_next.soft_value = '0;
                        out_data_next.status = STAT_OK;
                    end
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_READ:
            begin
                load = 1'b1;
                out_data_next.soft_value = rdata_reg;
                out_data_next.status = STAT_OK;
                state_next = S_IDLE;
            end
            S_ACC:
            begin
                we = 1'b1;
                load = 1'b1;
                out_data_next.soft_value = '0;
                out_data_next.status = STAT_OK;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            sweep_reg <= '0;
            reply_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            reply_reg <= reply_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (q_pop)
        begin
            sample_reg <= q_cmd.sample;
            addr_reg <= q_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[q_addr];
        end
    end

endmodule

/* src/conv_rate_dematcher_rx_top.sv */
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | crdm_pkg::req_t
// rsp     | out       | rsp_valid / rsp_ready | crdm_pkg::rsp_t
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A request is classified in the cycle it is taken; one queue of four entries feeds the back end.
// Replies load straight from idle; reads and accumulates wait on the registered RAM read port.
// A clear sweeps all 3*32*MAX_ROWS buffer RAM entries, one entry a cycle.
// After reset the same sweep runs, and req_ready stays low until it ends.
// A stalled rsp holds its register; requests keep entering until the queue fills.
module conv_rate_dematcher_rx_top #(
    parameter int MAX_ROWS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  crdm_pkg::req_t                    req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output crdm_pkg::rsp_t                    rsp_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [crdm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [crdm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import crdm_pkg::*;

    localparam int AW = $clog2(NUM_STREAMS * COLS * MAX_ROWS);
    localparam int QW = CMD_W + AW;

    logic          init_busy;
    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_empty;
    cmd_t          push_cmd;
    logic [AW-1:0] push_addr;
    cmd_t          pop_cmd;
    logic [AW-1:0] pop_addr;
    logic [QW-1:0] q_din;
    logic [QW-1:0] q_dout;

    assign q_din = {push_cmd, push_addr};
    assign pop_cmd = q_dout[QW-1:AW];
    assign pop_addr = q_dout[AW-1:0];

    crdm_front #(
        .MAX_ROWS(MAX_ROWS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data(req_data),
        .init_busy(init_busy),
        .q_full(q_full),
        .q_push(q_push),
        .q_cmd(push_cmd),
        .q_addr(push_addr)
    );

    crdm_queue #(
        .WIDTH(QW)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .din(q_din),
        .full(q_full),
        .pop(q_pop),
        .dout(q_dout),
        .empty(q_empty)
    );

    crdm_back #(
        .MAX_ROWS(MAX_ROWS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_empty(q_empty),
        .q_cmd(pop_cmd),
        .q_addr(pop_addr),
        .q_pop(q_pop),
        .init_busy(init_busy),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data(rsp_data)
    );

endmodule

/* tb/sv/tb_conv_rate_dematcher_rx_top.sv */
`timescale 1ns / 1ps

module tb_conv_rate_dematcher_rx_top;

    import crdm_pkg::*;

    localparam int MAX_ROWS = 8;
    localparam int STREAM_SPAN = COLS * MAX_ROWS;
    localparam int STORE_DEPTH = NUM_STREAMS * STREAM_SPAN;
    localparam int SAT = SAT_LIMIT;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int TAIL_CYCLES = 50;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        req_t req;
        bit   pinned;
        rsp_t rsp;
    } dir_row_t;

    typedef struct {
        logic [8:0]  len_d;
        logic [14:0] len_e;
        int          send_pct;
        int          recv_pct;
        int          items;
    } phase_t;

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req_data = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit   pin_on = 1'b0;
    rsp_t pin_rsp = '0;
    int   send_pct = 0;
    int   recv_pct = 0;

    logic signed [7:0] soft_mem [STORE_DEPTH];
    int          cur_stream;
    int          cur_col;
    int          cur_row;
    logic [14:0] sample_cnt;
    logic [8:0]  len_d;
    logic [14:0] len_e;

    rsp_t soft_reply_q [$];
    int   err_count = 0;
    int   n_checked = 0;
    int   n_clears = 0;
    int   n_accs = 0;
    int   n_reads = 0;
    int   n_other = 0;
    int   cycle_cnt = 0;

    conv_rate_dematcher_rx_top #(
        .MAX_ROWS(MAX_ROWS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data(rsp_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int coded_len();
        int dd;
        dd = int'(len_d);
        if (dd == 0) dd = 1;
        if (dd > STREAM_SPAN) dd = STREAM_SPAN;
        return dd;
    endfunction

    function automatic void home_cursor();
        cur_stream = 0;
        cur_col = 0;
        cur_row = 0;
    endfunction

    function automatic rsp_t dematch_step(req_t r);
        rsp_t res;
        int   dd;
        int   rows;
        int   shift;
        int   pcol;
        int   idx;
        int   sum;
        int   s;
        int   g;
        bit   placed;
        res.soft_value = '0;
        res.status = STAT_OK;
        dd = coded_len();
        rows = (dd + COLS - 1) / COLS;
        shift = rows * COLS - dd;
        case (r.func)
            FUNC_CLEAR:
            begin
                foreach (soft_mem[i]) soft_mem[i] = '0;
                home_cursor();
                sample_cnt = '0;
            end
            FUNC_ACC:
            begin
                if (sample_cnt >= len_e)
                begin
                    res.status = STAT_IGNORED;
                end
                else
                begin
                    if (cur_stream >= NUM_STREAMS || cur_row >= rows) home_cursor();
                    s = r.sample;
                    if (s < -SAT) s = -SAT;
                    placed = 1'b0;
                    for (g = 0; g < STORE_DEPTH && !placed; g++)
                    begin
                        pcol = COL_PERM[cur_col];
                        // skip row-0 pad slots
                        if (cur_row != 0 || pcol >= shift)
                        begin
                            idx = cur_stream * STREAM_SPAN + cur_row * COLS + pcol;
                            sum = soft_mem[idx] + s;
                            if (sum > SAT) sum = SAT;
                            if (sum < -SAT) sum = -SAT;
                            soft_mem[idx] = 8'(sum);
                            placed = 1'b1;
                        end
                        cur_row++;
                        if (cur_row >= rows)
                        begin
                            cur_row = 0;
                            cur_col++;
                            if (cur_col >= COLS)
                            begin
                                cur_col = 0;
                                cur_stream++;
                                if (cur_stream >= NUM_STREAMS) cur_stream = 0;
                            end
                        end
                    end
                    sample_cnt = sample_cnt + 15'd1;
                end
            end
            FUNC_READ:
            begin
                if (r.stream >= NUM_STREAMS || r.bit_index >= dd)
                    res.status = STAT_BAD_READ;
                else
                    res.soft_value = soft_mem[r.stream * STREAM_SPAN + r.bit_index + shift];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic req_t pick_request(int dlen);
        req_t r;
        int   roll;
        r.func = FUNC_ACC;
        r.sample = 8'($urandom);
        r.stream = 2'($urandom_range(NUM_STREAMS - 1));
        r.bit_index = 8'($urandom_range(dlen - 1));
        roll = $urandom_range(99);
        if (roll < 2)
            r.func = FUNC_CLEAR;
        else if (roll < 5)
            r.func = FUNC_UNUSED;
        else if (roll >= 57)
            r.func = FUNC_READ;
        if ($urandom_range(9) == 0)
        begin
            case ($urandom_range(2))
                0: r.sample = 8'sh80;
                1: r.sample = 8'sh7f;
                default: r.sample = 8'sh81;
            endcase
        end
        if ($urandom_range(19) == 0) r.stream = 2'd3;
        if ($urandom_range(6) == 0) r.bit_index = 8'($urandom);
        return r;
    endfunction

    function automatic dir_row_t mk_row(logic [1:0] f, logic signed [7:0] smp,
                                        logic [1:0] st, logic [7:0] bi,
                                        bit pin, logic [1:0] stat);
        dir_row_t d;
        d.req.func = f;
        d.req.sample = smp;
        d.req.stream = st;
        d.req.bit_index = bi;
        d.pinned = pin;
        d.rsp.soft_value = '0;
        d.rsp.status = stat;
        return d;
    endfunction

    // called just after a falling edge; returns just after the falling edge that follows
    // acceptance, with req_valid still high
    task automatic send_request(input req_t r, input bit pin, input rsp_t want);
        while ($urandom_range(99) < send_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_data <= r;
        pin_on <= pin;
        pin_rsp <= want;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (soft_reply_q.size() != 0) @(negedge clk);
    endtask

    task automatic set_lengths(input logic [8:0] d, input logic [14:0] e);
        cfg_index <= CFG_LENGTH_D;
        cfg_data <= CFG_DATA_W'(d);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_index <= CFG_LENGTH_E;
        cfg_data <= e;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= recv_pct);
    end

    always @(posedge clk)
    begin : monitor
        rsp_t want;
        rsp_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_LENGTH_D)
                begin
                    len_d = cfg_data[8:0];
                    home_cursor();
                end
                else if (cfg_index == CFG_LENGTH_E)
                begin
                    len_e = cfg_data;
                end
            end
            if (req_valid && req_ready)
            begin
                case (req_data.func)
                    FUNC_CLEAR: n_clears++;
                    FUNC_ACC: n_accs++;
                    FUNC_READ: n_reads++;
                    default: n_other++;
                endcase
                want = dematch_step(req_data);
                if (pin_on) want = pin_rsp;
                soft_reply_q.push_back(want);
            end
            if (rsp_valid && rsp_ready)
            begin
                got = rsp_data;
                if (soft_reply_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected reply soft %0d status %0d",
                             $realtime, got.soft_value, got.status);
                end
                else
                begin
                    want = soft_reply_q.pop_front();
                    n_checked++;
                    if (got.soft_value !== want.soft_value || got.status !== want.status)
                    begin
                        err_count++;
                        $display("%0t: reply mismatch: expected soft %0d status %0d, got soft %0d status %0d",
                                 $realtime, want.soft_value, want.status,
                                 got.soft_value, got.status);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d replies outstanding",
                     $realtime, soft_reply_q.size());
            $display("tb_conv_rate_dematcher_rx_top: errors");
            $finish;
        end
    end

    initial
    begin
        dir_row_t dir_rows [$];
        phase_t   phases [$];
        phase_t   ph;
        rsp_t     none;

        none = '0;
        foreach (soft_mem[i]) soft_mem[i] = '0;
        home_cursor();
        sample_cnt = '0;
        len_d = LENGTH_D_RESET;
        len_e = LENGTH_E_RESET;

        // reset lengths: D = 40, two rows, 24 pad slots per stream
        dir_rows.push_back(mk_row(FUNC_READ, 8'sd0, 2'd0, 8'd0, 1'b1, STAT_OK));
        dir_rows.push_back(mk_row(FUNC_READ, 8'sd0, 2'd2, 8'd39, 1'b1, STAT_OK));
        dir_rows.push_back(mk_row(FUNC_READ, 8'sd0, 2'd0, 8'd40, 1'b1, STAT_BAD_READ));
        dir_rows.push_back(mk_row(FUNC_READ, 8'sd0, 2'd3, 8'd0, 1'b1, STAT_BAD_READ));
        dir_rows.push_back(mk_row(FUNC_READ, 8'sd0, 2'd1, 8'd255, 1'b1, STAT_BAD_READ));
        dir_rows.push_back(mk_row(FUNC_UNUSED, 8'sh80, 2'd3, 8'd255, 1'b1, STAT_OK));
        dir_rows.push_back(mk_row(FUNC_ACC, 8'sh7f, 2'd0, 8'd0, 1'b1, STAT_OK));
        dir_rows.push_back(mk_row(FUNC_ACC, 8'sh80, 2'd0, 8'd0, 1'b1, STAT_OK));
        dir_rows.push_back(mk_row(FUNC_ACC, -8'sd1, 2'd0, 8'd0, 1'b0, STAT_OK));
        dir_rows.push_back(mk_row(FUNC_ACC, 8'sd0, 2'd0, 8'd0, 1'b0, STAT_OK));
        dir_rows.push_back(mk_row(FUNC_ACC, 8'sd1, 2'd0, 8'd0, 1'b0, STAT_OK));
        dir_rows.push_back(mk_row(FUNC_ACC, 8'sd127, 2'd0, 8'd0, 1'b0, STAT_OK));
        dir_rows.push_back(mk_row(FUNC_READ, 8'sd0, 2'd0, 8'd9, 1'b0, STAT_OK));
        dir_rows.push_back(mk_row(FUNC_READ, 8'sd0, 2'd0, 8'd25, 1'b0, STAT_OK));
        dir_rows.push_back(mk_row(FUNC_READ, 8'sd0, 2'd0, 8'd39, 1'b0, STAT_OK));
        dir_rows.push_back(mk_row(FUNC_READ, 8'sd0, 2'd1, 8'd0, 1'b0, STAT_OK));
        dir_rows.push_back(mk_row(FUNC_CLEAR, 8'sd0, 2'd0, 8'd0, 1'b1, STAT_OK));
        dir_rows.push_back(mk_row(FUNC_READ, 8'sd0, 2'd0, 8'd9, 1'b1, STAT_OK));
        dir_rows.push_back(mk_row(FUNC_ACC, 8'sh80, 2'd0, 8'd0, 1'b0, STAT_OK));
        dir_rows.push_back(mk_row(FUNC_READ, 8'sd0, 2'd0, 8'd9, 1'b0, STAT_OK));

        phases.push_back('{9'd40, 15'd120, 0, 0, 100});
        phases.push_back('{9'd1, 15'd28800, 63, 0, 80});
        phases.push_back('{9'd256, 15'd768, 0, 63, 120});
        phases.push_back('{9'd0, 15'd5, 18, 18, 60});
        phases.push_back('{9'd511, 15'd32767, 0, 0, 100});
        phases.push_back('{9'd33, 15'd0, 63, 0, 40});
        phases.push_back('{9'd100, 15'd300, 0, 63, 110});
        phases.push_back('{9'd7, 15'd1000, 18, 18, 110});

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].pinned, dir_rows[i].rsp);

        foreach (phases[p])
        begin
            ph = phases[p];
            drain();
            send_pct = 0;
            recv_pct = 0;
            set_lengths(ph.len_d, ph.len_e);
            send_pct = ph.send_pct;
            recv_pct = ph.recv_pct;
            send_request('{FUNC_CLEAR, 8'sd0, 2'd0, 8'd0}, 1'b0, none);
            repeat (ph.items) send_request(pick_request(coded_len()), 1'b0, none);
        end

        drain();
        recv_pct = 0;
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Covered %0d length settings: %0d clears, %0d accumulates, %0d reads, %0d no-ops",
                 phases.size() + 1, n_clears, n_accs, n_reads, n_other);
        $display("Checked %0d replies, %0d mismatches", n_checked, err_count);
        if (err_count == 0)
            $display("tb_conv_rate_dematcher_rx_top: clean");
        else
            $display("tb_conv_rate_dematcher_rx_top: errors");
        $finish;
    end

endmodule

/* files.f */
src/crdm_pkg.sv
src/crdm_queue.sv
src/crdm_front.sv
src/crdm_back.sv
src/conv_rate_dematcher_rx_top.sv
tb/sv/tb_conv_rate_dematcher_rx_top.sv
